// ----- sv/tsr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Topological sort package
// Shared widths, payload structs and sequencer states of the sort unit.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int unsigned MaxVerticesDef = 16;
  localparam int unsigned RowW           = 16;
  localparam int unsigned VertexW        = 4;

  typedef struct packed {
    logic [RowW-1:0] row_bits;
    logic            last_row;
  } tsr_in_t;

  typedef struct packed {
    logic [VertexW-1:0] vertex;
    logic               has_vertex;
    logic               last_of_run;
    logic               complete;
  } tsr_out_t;

  typedef enum logic [2:0] {
    StIdle,
    StPrime,
    StIndeg,
    StScan,
    StPop,
    StDec,
    StFinal
  } tsr_state_e;

endpackage

// ----- sv/topological_sort_source_removal_unit.sv -----
// order: rows are taken while idle; after the last row the in-degrees are built,
//   then source scans, pops and in-degree updates run before the final result
// throughput: one job at a time, set by the source scan that checks one vertex
//   per cycle in every round, plus one pop and one in-degree update per vertex
// reset: clears the sequencer, in-degrees and counters; row store and ready
//   stack contents stay undefined until written
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Topological sort, source removal
// Takes an adjacency matrix row by row and returns the vertices in
// topological order, flagging an ordering cut short by a cycle.
// ----------------------------------------------------------------------------
module topological_sort_source_removal_unit #(
  parameter int unsigned MAX_VERTICES = tsr_pkg::MaxVerticesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tsr_pkg::tsr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tsr_pkg::tsr_out_t out_data_o
);

  localparam int unsigned Cap  = (MAX_VERTICES < tsr_pkg::RowW) ? MAX_VERTICES
                                                                 : tsr_pkg::RowW;
  localparam int unsigned IdxW = $clog2(Cap);

  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  logic [IdxW-1:0]   rd_addr;
  logic [Cap-1:0]    rd_row;
  logic              res_valid;
  logic              res_ready;
  tsr_pkg::tsr_out_t res_data;

  logic              out_valid_q;
  tsr_pkg::tsr_out_t out_q;

  tsr_adj_store #(
    .DEPTH(Cap)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_row_i (in_data_i.row_bits[Cap-1:0]),
    .rd_addr_i(rd_addr),
    .rd_row_o (rd_row)
  );

  tsr_sort_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_row),
    .in_stall_o (in_stall_o),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr),
    .rd_row_i   (rd_row),
    .res_valid_o(res_valid),
    .res_data_o (res_data),
    .res_ready_i(res_ready)
  );

  // output register frees when empty or when its transfer completes
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last_row |=> in_stall_o)
    else $error("input taken right after a last row");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_vertex |-> out_data_o.last_of_run)
    else $error("empty result not marked last");

  a_complete_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.complete |-> out_data_o.last_of_run)
    else $error("complete flag on a result that is not last");

  a_no_load_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !res_valid)
    else $error("result loaded over a stalled transfer");
`endif

endmodule

// ----- sv/tsr_adj_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adjacency row store
// One row per vertex, written at one address and read through a registered
// port at one address.
// ----------------------------------------------------------------------------
module tsr_adj_store #(
  parameter int unsigned DEPTH = tsr_pkg::MaxVerticesDef
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DEPTH-1:0]         wr_row_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DEPTH-1:0]         rd_row_o
);

  logic [DEPTH-1:0] rows_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rows_q[wr_addr_i] <= wr_row_i;
    end
    rd_row_o <= rows_q[rd_addr_i];
  end

endmodule

// ----- sv/tsr_sort_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sort sequencer
// Loads rows, builds in-degrees, scans one vertex per cycle for sources,
// keeps the ready stack and produces the ordered results.
// ----------------------------------------------------------------------------
module tsr_sort_ctrl #(
  parameter int unsigned MAX_VERTICES = tsr_pkg::MaxVerticesDef,
  localparam int unsigned Cap  = (MAX_VERTICES < tsr_pkg::RowW) ? MAX_VERTICES
                                                                 : tsr_pkg::RowW,
  localparam int unsigned IdxW = $clog2(Cap)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_stall_o,
  output logic             wr_en_o,
  output logic [IdxW-1:0]  wr_addr_o,
  output logic [IdxW-1:0]  rd_addr_o,
  input  logic [Cap-1:0]   rd_row_i,
  output logic             res_valid_o,
  output tsr_pkg::tsr_out_t res_data_o,
  input  logic             res_ready_i
);

  localparam int unsigned CntW  = $clog2(Cap + 1);
  localparam int unsigned VertW = tsr_pkg::VertexW;

  tsr_pkg::tsr_state_e state_q, state_d;

  logic [CntW-1:0] rows_q, rows_d;
  logic [CntW-1:0] n_q, n_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] indeg_q [Cap];
  logic [CntW-1:0] indeg_d [Cap];
  logic [Cap-1:0]  removed_q, removed_d;
  logic [IdxW-1:0] stack_q [Cap];
  logic [IdxW-1:0] stack_d [Cap];
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] emitted_q, emitted_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] pend_v_q, pend_v_d;

  logic [CntW-1:0] top_idx;
  logic            cnt_last;

  assign top_idx   = fill_q - CntW'(1);
  assign cnt_last  = (CntW'(cnt_q) == (n_q - CntW'(1)));
  assign wr_addr_o = rows_q[IdxW-1:0];

  always_comb begin
    state_d     = state_q;
    rows_d      = rows_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    indeg_d     = indeg_q;
    removed_d   = removed_q;
    stack_d     = stack_q;
    fill_d      = fill_q;
    emitted_d   = emitted_q;
    pend_d      = pend_q;
    pend_v_d    = pend_v_q;
    in_stall_o  = 1'b1;
    wr_en_o     = 1'b0;
    rd_addr_o   = cnt_q;
    res_valid_o = 1'b0;
    res_data_o  = '0;

    case (state_q)
      tsr_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (rows_q < CntW'(Cap)) begin
            wr_en_o = 1'b1;
            rows_d  = rows_q + CntW'(1);
          end
          if (in_last_i) begin
            n_d     = rows_d;
            cnt_d   = '0;
            state_d = tsr_pkg::StPrime;
          end
        end
      end

      // first row read goes out here
      tsr_pkg::StPrime: begin
        state_d = tsr_pkg::StIndeg;
      end

      tsr_pkg::StIndeg: begin
        for (int i = 0; i < Cap; i++) begin
          if ((CntW'(i) < n_q) && rd_row_i[i]) begin
            indeg_d[i] = indeg_q[i] + CntW'(1);
          end
        end
        cnt_d = cnt_q + IdxW'(1);
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = tsr_pkg::StScan;
        end
        rd_addr_o = cnt_d;
      end

      tsr_pkg::StScan: begin
        if (!removed_q[cnt_q] && (indeg_q[cnt_q] == '0)) begin
          stack_d[fill_q[IdxW-1:0]] = cnt_q;
          fill_d                    = fill_q + CntW'(1);
          removed_d[cnt_q]          = 1'b1;
        end
        cnt_d = cnt_q + IdxW'(1);
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = tsr_pkg::StPop;
        end
      end

      tsr_pkg::StPop: begin
        rd_addr_o = stack_q[top_idx[IdxW-1:0]];
        if (fill_q == '0) begin
          state_d = tsr_pkg::StFinal;
        end else if (!pend_q || res_ready_i) begin
          if (pend_q) begin
            res_valid_o            = 1'b1;
            res_data_o.vertex      = VertW'(pend_v_q);
            res_data_o.has_vertex  = 1'b1;
          end
          pend_d   = 1'b1;
          pend_v_d = stack_q[top_idx[IdxW-1:0]];
          fill_d   = top_idx;
          state_d  = tsr_pkg::StDec;
        end
      end

      tsr_pkg::StDec: begin
        for (int i = 0; i < Cap; i++) begin
          if ((CntW'(i) < n_q) && rd_row_i[i] && (indeg_q[i] != '0)) begin
            indeg_d[i] = indeg_q[i] - CntW'(1);
          end
        end
        emitted_d = emitted_q + CntW'(1);
        state_d   = tsr_pkg::StScan;
      end

      tsr_pkg::StFinal: begin
        if (res_ready_i) begin
          res_valid_o            = 1'b1;
          res_data_o.last_of_run = 1'b1;
          if (pend_q) begin
            res_data_o.vertex     = VertW'(pend_v_q);
            res_data_o.has_vertex = 1'b1;
            res_data_o.complete   = (emitted_q == n_q);
          end
          rows_d    = '0;
          removed_d = '0;
          fill_d    = '0;
          emitted_d = '0;
          pend_d    = 1'b0;
          for (int i = 0; i < Cap; i++) begin
            indeg_d[i] = '0;
          end
          state_d = tsr_pkg::StIdle;
        end
      end

      default: begin
        state_d = tsr_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tsr_pkg::StIdle;
      rows_q    <= '0;
      n_q       <= '0;
      cnt_q     <= '0;
      removed_q <= '0;
      fill_q    <= '0;
      emitted_q <= '0;
      pend_q    <= 1'b0;
      for (int i = 0; i < Cap; i++) begin
        indeg_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      rows_q    <= rows_d;
      n_q       <= n_d;
      cnt_q     <= cnt_d;
      removed_q <= removed_d;
      fill_q    <= fill_d;
      emitted_q <= emitted_d;
      pend_q    <= pend_d;
      indeg_q   <= indeg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stack_q  <= stack_d;
    pend_v_q <= pend_v_d;
  end

endmodule
